/* rtl/core/pfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, register indexes and the layout decode / encode functions of
// the pixel format converter.
// ----------------------------------------------------------------------------
package pfc_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_SOURCE_FORMAT   = 2'd0;
    localparam logic [1:0] CFG_TARGET_FORMAT   = 2'd1;
    localparam logic [1:0] CFG_CLUT_SWIZZLED   = 2'd2;
    localparam logic [1:0] CFG_NIBBLES_FLIPPED = 2'd3;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_CONVERT = 1'b1;

    localparam int NUM_LAYOUTS = 24;

    typedef enum logic [1:0] {
        KIND_16,
        KIND_24,
        KIND_32
    } kind_t;

    typedef enum logic [1:0] {
        GRP_DIRECT,
        GRP_PAL8,
        GRP_PAL4
    } src_group_t;

    typedef struct packed {
        kind_t      kind;
        logic [4:0] pos_r;
        logic [4:0] pos_g;
        logic [4:0] pos_b;
        logic [4:0] pos_a;
        logic [4:0] pos_u;
        logic [3:0] bits_r;
        logic [3:0] bits_g;
        logic [3:0] bits_b;
        logic [3:0] bits_a;
        logic [3:0] bits_u;
    } layout_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } rgba_t;

    function automatic layout_t mk_layout(kind_t k, int pr, int pg, int pb, int pa, int pu,
                                          int br, int bg, int bb, int ba, int bu);
        layout_t l;
        l.kind   = k;
        l.pos_r  = 5'(pr);
        l.pos_g  = 5'(pg);
        l.pos_b  = 5'(pb);
        l.pos_a  = 5'(pa);
        l.pos_u  = 5'(pu);
        l.bits_r = 4'(br);
        l.bits_g = 4'(bg);
        l.bits_b = 4'(bb);
        l.bits_a = 4'(ba);
        l.bits_u = 4'(bu);
        return l;
    endfunction

    // layouts in register order, zero based; RGB family then BGR family
    function automatic layout_t layout_of(logic [4:0] idx);
        layout_t l;
        unique case (idx)
            5'd0:  l = mk_layout(KIND_32, 24, 16,  8,  0,  0, 8, 8, 8, 8, 0);
            5'd1:  l = mk_layout(KIND_32, 24, 16,  8,  0,  0, 8, 8, 8, 0, 8);
            5'd2:  l = mk_layout(KIND_32, 16,  8,  0, 24,  0, 8, 8, 8, 8, 0);
            5'd3:  l = mk_layout(KIND_32, 16,  8,  0,  0, 24, 8, 8, 8, 0, 8);
            5'd4:  l = mk_layout(KIND_24, 16,  8,  0,  0,  0, 8, 8, 8, 0, 0);
            5'd5:  l = mk_layout(KIND_16, 12,  8,  4,  0,  0, 4, 4, 4, 4, 0);
            5'd6:  l = mk_layout(KIND_16,  8,  4,  0, 12,  0, 4, 4, 4, 4, 0);
            5'd7:  l = mk_layout(KIND_16, 11,  6,  1,  0,  0, 5, 5, 5, 1, 0);
            5'd8:  l = mk_layout(KIND_16, 11,  6,  1,  0,  0, 5, 5, 5, 0, 1);
            5'd9:  l = mk_layout(KIND_16, 10,  5,  0, 15,  0, 5, 5, 5, 1, 0);
            5'd10: l = mk_layout(KIND_16, 10,  5,  0,  0, 15, 5, 5, 5, 0, 1);
            5'd11: l = mk_layout(KIND_16, 11,  5,  0,  0,  0, 5, 6, 5, 0, 0);
            5'd12: l = mk_layout(KIND_32,  8, 16, 24,  0,  0, 8, 8, 8, 8, 0);
            5'd13: l = mk_layout(KIND_32,  8, 16, 24,  0,  0, 8, 8, 8, 0, 8);
            5'd14: l = mk_layout(KIND_32,  0,  8, 16, 24,  0, 8, 8, 8, 8, 0);
            5'd15: l = mk_layout(KIND_32,  0,  8, 16,  0, 24, 8, 8, 8, 0, 8);
            5'd16: l = mk_layout(KIND_24,  0,  8, 16,  0,  0, 8, 8, 8, 0, 0);
            5'd17: l = mk_layout(KIND_16,  4,  8, 12,  0,  0, 4, 4, 4, 4, 0);
            5'd18: l = mk_layout(KIND_16,  0,  4,  8, 12,  0, 4, 4, 4, 4, 0);
            5'd19: l = mk_layout(KIND_16,  1,  6, 11,  0,  0, 5, 5, 5, 1, 0);
            5'd20: l = mk_layout(KIND_16,  1,  6, 11,  0,  0, 5, 5, 5, 0, 1);
            5'd21: l = mk_layout(KIND_16,  0,  5, 10, 15,  0, 5, 5, 5, 1, 0);
            5'd22: l = mk_layout(KIND_16,  0,  5, 10,  0, 15, 5, 5, 5, 0, 1);
            5'd23: l = mk_layout(KIND_16,  0,  5, 11,  0,  0, 5, 6, 5, 0, 0);
            default: l = mk_layout(KIND_32, 24, 16, 8, 0, 0, 8, 8, 8, 8, 0);
        endcase
        return l;
    endfunction

    // pull a field out of the word and widen it to 8 bits by replication
    function automatic logic [7:0] widen(logic [31:0] v, logic [3:0] b, logic [4:0] p);
        logic [31:0] s;
        logic [7:0]  f;
        logic [7:0]  x;
        s = v >> p;
        f = s[7:0];
        unique case (b)
            4'd1:    x = {8{f[0]}};
            4'd4:    x = {f[3:0], f[3:0]};
            4'd5:    x = {f[4:0], f[4:2]};
            4'd6:    x = {f[5:0], f[5:4]};
            default: x = f;
        endcase
        return x;
    endfunction

    function automatic rgba_t decode(logic [31:0] v, layout_t l);
        rgba_t c;
        c.r = widen(v, l.bits_r, l.pos_r);
        c.g = widen(v, l.bits_g, l.pos_g);
        c.b = widen(v, l.bits_b, l.pos_b);
        if (l.bits_a != 4'd0)
            c.a = widen(v, l.bits_a, l.pos_a);
        else if (l.kind == KIND_32 && l.bits_u != 4'd0)
            c.a = widen(v, l.bits_u, l.pos_u);
        else
            c.a = 8'hFF;
        return c;
    endfunction

    function automatic logic [31:0] place(logic [7:0] ch, logic [3:0] b, logic [4:0] p);
        logic [7:0] top;
        top = ch >> (4'd8 - b);
        return (b == 4'd0) ? 32'd0 : ({24'd0, top} << p);
    endfunction

    function automatic logic [31:0] encode(rgba_t c, layout_t l);
        logic [8:0]  ones;
        logic [31:0] w;
        ones = (9'd1 << l.bits_u) - 9'd1;
        w = (l.bits_u == 4'd0) ? 32'd0 : ({24'd0, ones[7:0]} << l.pos_u);
        w = w | place(c.r, l.bits_r, l.pos_r) | place(c.g, l.bits_g, l.pos_g)
              | place(c.b, l.bits_b, l.pos_b) | place(c.a, l.bits_a, l.pos_a);
        unique case (l.kind)
            KIND_16: w[31:16] = 16'd0;
            KIND_24: w[31:24] = 8'd0;
            default: ;
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/pfc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module pfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* rtl/core/pixel_format_converter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_converter_unit
// Converts pixel words between 16/24/32-bit RGB/BGR layouts, with 8-bit and
// 4-bit palette sources backed by a decoded palette RAM.
//
//  channel  | signals                    | content
//  ---------+----------------------------+--------------------------------
//  s_axis   | tvalid tready tdata tuser  | load entry / convert word
//  m_axis   | tvalid tready tdata tlast  | decoded pixel, 1 or 2 per convert
//  cfg      | cfg_we cfg_index cfg_data  | format and palette options
//
// One item enters per cycle unless a stall holds the pipe; a 4-bit palette
// item holds the output register for one transfer per nibble pixel. Each
// result passes through input reg, decode, palette read and encode. Loads
// leave the pipe after the palette write and give no transfer. Stalls back
// up stage by stage through per-stage valid bits. The palette RAM is not
// cleared on reset.
// ----------------------------------------------------------------------------
module pixel_format_converter_unit #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // entry_index[7:0], word_in[39:8]
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // red, green, blue, alpha, packed_res[63:32]
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int         ADDR_W    = $clog2(PALETTE_DEPTH);
    localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [6:0] source_format_reg;
    logic [4:0] target_format_reg;
    logic       clut_swizzled_reg;
    logic       nibbles_flipped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_format_reg   <= 7'd1;
            target_format_reg   <= 5'd1;
            clut_swizzled_reg   <= 1'b0;
            nibbles_flipped_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pfc_pkg::CFG_SOURCE_FORMAT:   source_format_reg   <= cfg_data;
                pfc_pkg::CFG_TARGET_FORMAT:   target_format_reg   <= cfg_data[4:0];
                pfc_pkg::CFG_CLUT_SWIZZLED:   clut_swizzled_reg   <= cfg_data[0];
                pfc_pkg::CFG_NIBBLES_FLIPPED: nibbles_flipped_reg <= cfg_data[0];
            endcase
        end
    end

    logic [6:0]          src_eff;
    logic [6:0]          src_off;
    logic [6:0]          src_lidx;
    logic [4:0]          tgt_eff;
    logic [4:0]          tgt_lidx;
    pfc_pkg::src_group_t src_grp;
    pfc_pkg::layout_t    src_lay;
    pfc_pkg::layout_t    tgt_lay;
    logic                same_fmt;

    always_comb
    begin
        src_eff = (source_format_reg == 7'd0 || source_format_reg > 7'd72)
                  ? 7'd1 : source_format_reg;
        if (src_eff <= 7'd24)
        begin
            src_grp = pfc_pkg::GRP_DIRECT;
            src_off = 7'd0;
        end
        else if (src_eff <= 7'd48)
        begin
            src_grp = pfc_pkg::GRP_PAL8;
            src_off = 7'd24;
        end
        else
        begin
            src_grp = pfc_pkg::GRP_PAL4;
            src_off = 7'd48;
        end
        src_lidx = src_eff - 7'd1 - src_off;
        tgt_eff  = (target_format_reg == 5'd0 || target_format_reg > 5'd24)
                   ? 5'd1 : target_format_reg;
        tgt_lidx = tgt_eff - 5'd1;
        src_lay  = pfc_pkg::layout_of(src_lidx[4:0]);
        tgt_lay  = pfc_pkg::layout_of(tgt_lidx);
        same_fmt = (src_grp == pfc_pkg::GRP_DIRECT) && (src_eff == {2'b00, tgt_eff});
    end

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic phase_reg, phase_next;
    logic rdy1, rdy2, rdy3, rdy4;
    logic leave2;

    logic        act1_reg;
    logic [7:0]  idx1_reg;
    logic [31:0] word1_reg;

    logic          act2_reg;
    logic [31:0]   word2_reg;
    pfc_pkg::rgba_t dec2_reg;
    logic [7:0]    wpos2_reg;
    logic          wok2_reg;
    logic [7:0]    ra2_reg;
    logic [7:0]    rb2_reg;
    logic          oob_a2_reg;
    logic          oob_b2_reg;

    logic [31:0]    word3_reg;
    pfc_pkg::rgba_t dec3_reg;
    logic           oob_a3_reg;
    logic           oob_b3_reg;

    logic           two4_reg;
    pfc_pkg::rgba_t c0_4_reg, c1_4_reg;
    logic [31:0]    p0_4_reg, p1_4_reg;

    assign rdy4   = !v4_reg || (m_axis_tready && (!two4_reg || phase_reg));
    assign rdy3   = !v3_reg || rdy4;
    assign leave2 = v2_reg && (act2_reg == pfc_pkg::ACT_LOAD || rdy3);
    assign rdy2   = !v2_reg || leave2;
    assign rdy1   = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    always_comb
    begin
        phase_next = phase_reg;
        if (v4_reg && m_axis_tready)
        begin
            phase_next = two4_reg && !phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (rdy1)
                v1_reg <= s_axis_tvalid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg && act2_reg == pfc_pkg::ACT_CONVERT;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: input register
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (rdy1 && s_axis_tvalid)
        begin
            act1_reg  <= s_axis_tuser;
            idx1_reg  <= s_axis_tdata[7:0];
            word1_reg <= s_axis_tdata[39:8];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: source decode, palette addresses
    // ------------------------------------------------------------------
    logic [7:0] wpos_next;
    logic [7:0] ra_next, rb_next;
    logic [3:0] nib_hi, nib_lo;

    always_comb
    begin
        wpos_next = idx1_reg;
        if (src_grp == pfc_pkg::GRP_PAL8 && clut_swizzled_reg)
            wpos_next = {idx1_reg[7:5], idx1_reg[3], idx1_reg[4], idx1_reg[2:0]};
        nib_hi = word1_reg[7:4];
        nib_lo = word1_reg[3:0];
        if (src_grp == pfc_pkg::GRP_PAL4)
        begin
            ra_next = {4'd0, nibbles_flipped_reg ? nib_lo : nib_hi};
            rb_next = {4'd0, nibbles_flipped_reg ? nib_hi : nib_lo};
        end
        else
        begin
            ra_next = word1_reg[7:0];
            rb_next = word1_reg[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            act2_reg   <= act1_reg;
            word2_reg  <= word1_reg;
            dec2_reg   <= pfc_pkg::decode(word1_reg, src_lay);
            wpos2_reg  <= wpos_next;
            wok2_reg   <= {1'b0, wpos_next} < DEPTH_LIM;
            ra2_reg    <= ra_next;
            rb2_reg    <= rb_next;
            oob_a2_reg <= {1'b0, ra_next} >= DEPTH_LIM;
            oob_b2_reg <= {1'b0, rb_next} >= DEPTH_LIM;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: palette read (loads write here and leave the pipe)
    // ------------------------------------------------------------------
    logic        pal_we;
    logic        pal_re;
    logic [31:0] pal_a, pal_b;

    assign pal_we = v2_reg && act2_reg == pfc_pkg::ACT_LOAD && wok2_reg;
    assign pal_re = v2_reg && act2_reg == pfc_pkg::ACT_CONVERT && rdy3;

    pfc_ram #(
        .WIDTH (32),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .we      (pal_we),
        .waddr   (wpos2_reg[ADDR_W-1:0]),
        .wdata   (dec2_reg),
        .re      (pal_re),
        .raddr_a (ra2_reg[ADDR_W-1:0]),
        .raddr_b (rb2_reg[ADDR_W-1:0]),
        .rdata_a (pal_a),
        .rdata_b (pal_b)
    );

    always_ff @(posedge clk)
    begin
        if (pal_re)
        begin
            word3_reg  <= word2_reg;
            dec3_reg   <= dec2_reg;
            oob_a3_reg <= oob_a2_reg;
            oob_b3_reg <= oob_b2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: target encode, output register
    // ------------------------------------------------------------------
    pfc_pkg::rgba_t c0, c1;

    always_comb
    begin
        if (src_grp == pfc_pkg::GRP_DIRECT)
            c0 = dec3_reg;
        else
            c0 = oob_a3_reg ? '0 : pal_a;
        c1 = oob_b3_reg ? '0 : pal_b;
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            two4_reg <= src_grp == pfc_pkg::GRP_PAL4;
            c0_4_reg <= c0;
            c1_4_reg <= c1;
            p0_4_reg <= same_fmt ? word3_reg : pfc_pkg::encode(c0, tgt_lay);
            p1_4_reg <= pfc_pkg::encode(c1, tgt_lay);
        end
    end

    pfc_pkg::rgba_t out_c;
    logic [31:0]    out_p;

    assign out_c         = phase_reg ? c1_4_reg : c0_4_reg;
    assign out_p         = phase_reg ? p1_4_reg : p0_4_reg;
    assign m_axis_tvalid = v4_reg;
    assign m_axis_tlast  = !two4_reg || phase_reg;
    assign m_axis_tdata  = {out_p, out_c.a, out_c.b, out_c.g, out_c.r};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_phase_only_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (v4_reg && two4_reg))
        else $error("second-pixel phase without a two-pixel item");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && phase_reg))
        else $error("first nibble pixel not followed by second");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!v1_reg && !v2_reg && !v3_reg && !v4_reg) |-> s_axis_tready)
        else $error("empty pipeline refuses input");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !rdy4) |=> (v4_reg && $stable(p0_4_reg) && $stable(p1_4_reg)))
        else $error("output register changed under stall");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of pixel_format_converter_unit. A queue-fed driver
// offers palette loads and convert words. A shadow palette and a channel
// decoder/encoder predict every pixel transfer. The monitor compares each
// output transfer field by field. Formats change only while the pipe is
// empty. Backpressure and source gaps vary over the run.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic        action;
        logic [7:0]  entry;
        logic [31:0] word;
    } item_t;

    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [31:0] packed_px;
        logic        last;
    } px_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;    // entry_index[7:0], word_in[39:8]
    logic        s_axis_tuser = 1'b0;  // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // red, green, blue, alpha, packed_res[63:32]
    logic        m_axis_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [6:0]  cfg_data = '0;

    pixel_format_converter_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // word width, pos R G B A U, bits R G B A U
    int fmt_tab [24][11] = '{
        '{32, 24, 16,  8,  0,  0, 8, 8, 8, 8, 0},
        '{32, 24, 16,  8,  0,  0, 8, 8, 8, 0, 8},
        '{32, 16,  8,  0, 24,  0, 8, 8, 8, 8, 0},
        '{32, 16,  8,  0,  0, 24, 8, 8, 8, 0, 8},
        '{24, 16,  8,  0,  0,  0, 8, 8, 8, 0, 0},
        '{16, 12,  8,  4,  0,  0, 4, 4, 4, 4, 0},
        '{16,  8,  4,  0, 12,  0, 4, 4, 4, 4, 0},
        '{16, 11,  6,  1,  0,  0, 5, 5, 5, 1, 0},
        '{16, 11,  6,  1,  0,  0, 5, 5, 5, 0, 1},
        '{16, 10,  5,  0, 15,  0, 5, 5, 5, 1, 0},
        '{16, 10,  5,  0,  0, 15, 5, 5, 5, 0, 1},
        '{16, 11,  5,  0,  0,  0, 5, 6, 5, 0, 0},
        '{32,  8, 16, 24,  0,  0, 8, 8, 8, 8, 0},
        '{32,  8, 16, 24,  0,  0, 8, 8, 8, 0, 8},
        '{32,  0,  8, 16, 24,  0, 8, 8, 8, 8, 0},
        '{32,  0,  8, 16,  0, 24, 8, 8, 8, 0, 8},
        '{24,  0,  8, 16,  0,  0, 8, 8, 8, 0, 0},
        '{16,  4,  8, 12,  0,  0, 4, 4, 4, 4, 0},
        '{16,  0,  4,  8, 12,  0, 4, 4, 4, 4, 0},
        '{16,  1,  6, 11,  0,  0, 5, 5, 5, 1, 0},
        '{16,  1,  6, 11,  0,  0, 5, 5, 5, 0, 1},
        '{16,  0,  5, 10, 15,  0, 5, 5, 5, 1, 0},
        '{16,  0,  5, 10,  0, 15, 5, 5, 5, 0, 1},
        '{16,  0,  5, 11,  0,  0, 5, 6, 5, 0, 0}
    };

    // shadow of the block registers and palette
    logic [6:0]      src_cfg = 7'd1;
    logic [4:0]      tgt_cfg = 5'd1;
    logic            swz_cfg = 1'b0;
    logic            flip_cfg = 1'b0;
    pfc_pkg::rgba_t  clut_shadow [256];

    item_t       item_q [$];
    px_result_t  pixel_expect_q [$];
    item_t       cur_item;
    bit          in_taken = 1'b0;
    int          err_count = 0;

    // generator view of the phase, used to read only loaded entries
    bit          gen_written [256];
    int          g_group = 0;
    bit          g_swz = 1'b0;

    int          send_idle_pct = 11;
    int          recv_idle_pct = 67;
    int          hold_req = 0;

    function automatic logic [7:0] widen_chan(logic [31:0] v, int b, int p);
        logic [7:0] f;
        logic [7:0] x;
        f = 8'((v >> p) & ((32'd1 << b) - 32'd1));
        for (int i = 0; i < 8; i++)
            x[7 - i] = f[b - 1 - (i % b)];
        return x;
    endfunction

    function automatic pfc_pkg::rgba_t decode_px(logic [31:0] v, int n);
        pfc_pkg::rgba_t c;
        c.r = widen_chan(v, fmt_tab[n][6], fmt_tab[n][1]);
        c.g = widen_chan(v, fmt_tab[n][7], fmt_tab[n][2]);
        c.b = widen_chan(v, fmt_tab[n][8], fmt_tab[n][3]);
        if (fmt_tab[n][9] != 0)
            c.a = widen_chan(v, fmt_tab[n][9], fmt_tab[n][4]);
        else if (fmt_tab[n][0] == 32 && fmt_tab[n][10] != 0)
            c.a = widen_chan(v, fmt_tab[n][10], fmt_tab[n][5]);
        else
            c.a = 8'hFF;
        return c;
    endfunction

    function automatic logic [31:0] encode_px(pfc_pkg::rgba_t c, int n);
        logic [31:0] w;
        logic [7:0]  ch;
        int          b;
        w = '0;
        if (fmt_tab[n][10] != 0)
            w = ((32'd1 << fmt_tab[n][10]) - 32'd1) << fmt_tab[n][5];
        for (int k = 0; k < 4; k++)
        begin
            b = fmt_tab[n][6 + k];
            ch = 8'(c >> (24 - 8 * k));
            if (b != 0)
                w = w | (32'(ch >> (8 - b)) << fmt_tab[n][1 + k]);
        end
        if (fmt_tab[n][0] == 16)
            w = w & 32'h0000FFFF;
        else if (fmt_tab[n][0] == 24)
            w = w & 32'h00FFFFFF;
        return w;
    endfunction

    function automatic void push_pixel(pfc_pkg::rgba_t c, logic [31:0] pk, logic lst);
        px_result_t r;
        r.red = c.r;
        r.green = c.g;
        r.blue = c.b;
        r.alpha = c.a;
        r.packed_px = pk;
        r.last = lst;
        pixel_expect_q.push_back(r);
    endfunction

    function automatic void predict_pixels(item_t it);
        int             sf;
        int             tf;
        int             grp;
        logic [7:0]     pos;
        pfc_pkg::rgba_t c;
        logic [3:0]     first;
        logic [3:0]     second;
        sf = (src_cfg < 1 || src_cfg > 72) ? 1 : int'(src_cfg);
        tf = (tgt_cfg < 1 || tgt_cfg > 24) ? 1 : int'(tgt_cfg);
        grp = (sf - 1) / 24;
        if (it.action == pfc_pkg::ACT_LOAD)
        begin
            pos = it.entry;
            if (grp == 1 && swz_cfg)
                pos = {pos[7:5], pos[3], pos[4], pos[2:0]};
            clut_shadow[pos] = decode_px(it.word, (sf - 1) % 24);
        end
        else if (grp == 0)
        begin
            c = decode_px(it.word, sf - 1);
            push_pixel(c, (sf == tf) ? it.word : encode_px(c, tf - 1), 1'b1);
        end
        else if (grp == 1)
        begin
            c = clut_shadow[it.word[7:0]];
            push_pixel(c, encode_px(c, tf - 1), 1'b1);
        end
        else
        begin
            first = flip_cfg ? it.word[3:0] : it.word[7:4];
            second = flip_cfg ? it.word[7:4] : it.word[3:0];
            c = clut_shadow[first];
            push_pixel(c, encode_px(c, tf - 1), 1'b0);
            c = clut_shadow[second];
            push_pixel(c, encode_px(c, tf - 1), 1'b1);
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
        if (a !== e)
        begin
            $display("%0t: mismatch on %s: expected %h, got %h", $time, name, e, a);
            err_count++;
        end
    endfunction

    // source driver: hold an offer until it is taken
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            in_taken = 1'b0;
            if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cur_item = item_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {cur_item.word, cur_item.entry};
                s_axis_tuser <= cur_item.action;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink backpressure, with an occasional long hold-off on request
    int hold_left = 0;
    int hold_seen = 0;
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = 150;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor and predictor hookup
    always @(posedge clk)
    begin
        px_result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pixel_expect_q.size() == 0)
            begin
                $display("%0t: unexpected pixel transfer: expected none, got %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                err_count++;
            end
            else
            begin
                e = pixel_expect_q.pop_front();
                check_field("red", e.red, m_axis_tdata[7:0]);
                check_field("green", e.green, m_axis_tdata[15:8]);
                check_field("blue", e.blue, m_axis_tdata[23:16]);
                check_field("alpha", e.alpha, m_axis_tdata[31:24]);
                check_field("packed_res", e.packed_px, m_axis_tdata[63:32]);
                check_field("last", e.last, m_axis_tlast);
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_pixels(cur_item);
            in_taken = 1'b1;
        end
    end

    task automatic wait_idle();
        while (item_q.size() != 0 || s_axis_tvalid || pixel_expect_q.size() != 0)
            @(negedge clk);
        // loads still in flight leave no trace on the output
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            pfc_pkg::CFG_SOURCE_FORMAT:   src_cfg = val;
            pfc_pkg::CFG_TARGET_FORMAT:   tgt_cfg = val[4:0];
            pfc_pkg::CFG_CLUT_SWIZZLED:   swz_cfg = val[0];
            pfc_pkg::CFG_NIBBLES_FLIPPED: flip_cfg = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(int src, int tgt, bit swz, bit flip);
        int eff;
        wait_idle();
        write_reg(pfc_pkg::CFG_SOURCE_FORMAT, 7'(src));
        write_reg(pfc_pkg::CFG_TARGET_FORMAT, {2'($urandom_range(3)), 5'(tgt)});
        write_reg(pfc_pkg::CFG_CLUT_SWIZZLED, {6'($urandom), swz});
        write_reg(pfc_pkg::CFG_NIBBLES_FLIPPED, {6'($urandom), flip});
        eff = (src < 1 || src > 72) ? 1 : src;
        g_group = (eff - 1) / 24;
        g_swz = swz;
    endtask

    task automatic push_load(logic [7:0] idx, logic [31:0] word);
        item_t      it;
        logic [7:0] pos;
        pos = idx;
        if (g_group == 1 && g_swz)
            pos = {idx[7:5], idx[3], idx[4], idx[2:0]};
        gen_written[pos] = 1'b1;
        it.action = pfc_pkg::ACT_LOAD;
        it.entry = idx;
        it.word = word;
        item_q.push_back(it);
    endtask

    task automatic push_convert(logic [31:0] word);
        item_t it;
        it.action = pfc_pkg::ACT_CONVERT;
        it.entry = 8'($urandom);
        it.word = word;
        item_q.push_back(it);
    endtask

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 32'h00000000;
        else if (r < 16)
            return 32'hFFFFFFFF;
        return $urandom;
    endfunction

    task automatic gen_random(int n);
        int         r;
        bit         have;
        logic [7:0] a;
        logic [3:0] hi;
        logic [3:0] lo;
        have = 1'b0;
        for (int i = 0; i < (g_group == 2 ? 16 : 256); i++)
            have |= gen_written[i];
        if (!have && g_group != 0)
            push_load(8'(g_group == 2 ? $urandom_range(15) : $urandom_range(255)),
                      rand_word());
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (g_group == 0)
            begin
                if (r < 10)
                    push_load(8'($urandom), rand_word());
                else
                    push_convert(rand_word());
            end
            else if (r < 30)
            begin
                if (g_group == 2 && r < 21)
                    push_load(8'($urandom_range(15)), rand_word());
                else
                    push_load(8'($urandom), rand_word());
            end
            else if (g_group == 1)
            begin
                do a = 8'($urandom); while (!gen_written[a]);
                push_convert({24'($urandom), a});
            end
            else
            begin
                do hi = 4'($urandom); while (!gen_written[hi]);
                do lo = 4'($urandom); while (!gen_written[lo]);
                push_convert({24'($urandom), hi, lo});
            end
        end
    endtask

    int src_edges [8] = '{1, 24, 25, 48, 49, 72, 0, 127};
    int tgt_edges [8] = '{24, 1, 1, 24, 24, 1, 31, 0};

    initial
    begin
        int r;
        int src;
        int tgt;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // reset formats, same-format pass-through
        set_config(1, 1, 1'b0, 1'b0);
        push_convert(32'hFFFFFFFF);
        push_convert(32'h00000000);
        push_convert(32'hA5A5A5A5);

        // 565 source, junk above bit 15 is ignored
        set_config(12, 5, 1'b0, 1'b0);
        push_convert(32'h0000FFFF);
        push_convert(32'hFFFF0000);
        push_convert(32'h0000F800);
        push_convert(32'h000007E0);

        // 8-bit palette with swizzled load positions
        set_config(36, 24, 1'b1, 1'b0);
        push_load(8'h08, 32'h0000F800);
        push_load(8'h10, 32'h000007E0);
        push_load(8'h00, 32'hFFFFFFFF);
        push_load(8'hFF, 32'h00000000);
        push_convert(32'h00000008);
        push_convert(32'h00000010);
        push_convert(32'h00000000);
        push_convert(32'hFFFFFFFF);

        // 4-bit palette, low nibble first, bad target
        set_config(72, 31, 1'b0, 1'b1);
        push_load(8'h00, 32'h0000001F);
        push_load(8'h0F, 32'hFFFFFFFF);
        push_convert(32'h0000000F);
        push_convert(32'h000000F0);
        push_convert(32'hFFFFFF00);
        push_convert(32'h000000FF);

        // out-of-range formats fall back to the first layout
        set_config(0, 0, 1'b0, 1'b0);
        push_convert(32'hDEADBEEF);
        set_config(127, 25, 1'b1, 1'b1);
        push_convert(32'hFFFFFFFF);

        for (int p = 0; p < 18; p++)
        begin
            case ((p * 3) / 18)
                0:
                begin
                    send_idle_pct = 11;
                    recv_idle_pct = 67;
                end
                1:
                begin
                    send_idle_pct = 67;
                    recv_idle_pct = 11;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (p < 8)
            begin
                src = src_edges[p];
                tgt = tgt_edges[p];
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 40)
                    src = $urandom_range(24, 1);
                else if (r < 65)
                    src = $urandom_range(48, 25);
                else if (r < 90)
                    src = $urandom_range(72, 49);
                else
                    src = ($urandom_range(1) != 0) ? 0 : $urandom_range(127, 73);
                tgt = ($urandom_range(9) == 0) ? $urandom_range(31, 25) * $urandom_range(1)
                                               : $urandom_range(24, 1);
            end
            set_config(src, tgt, 1'($urandom), 1'($urandom));
            gen_random(78);
            // fill the pipe against a stalled sink while the source keeps offering
            if (p == 14)
                hold_req++;
        end

        wait_idle();
        repeat (20) @(negedge clk);
        if (err_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("testbench failed");
        $finish;
    end

endmodule
